[rtl/core/buddy_page_allocator_defines.svh]
// Assertion macros for the buddy page allocator.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");
`define BPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");
`else
`define BPA_ASSERT_IMP(lbl, ante, cons)
`define BPA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/bpa_pkg.sv]
package bpa_pkg;

    localparam int ORDER_LIMIT = 14;
    localparam int PAGE_W      = 14;
    localparam int CNT_W       = 15;
    localparam int ORD_W       = 5;
    localparam int PAGES       = 1 << ORDER_LIMIT;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADSIZE = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // One entry per page; only meaningful at the first page of a block
    typedef struct packed {
        logic       used;
        logic       free;
        logic [3:0] order;
    } t_blk;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        t_blk              wdata;
        logic              re;
        logic [PAGE_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [CNT_W-1:0] pow2(input logic [ORD_W-1:0] j);
        pow2 = CNT_W'(1) << j;
    endfunction

    // Index of the highest set bit, zero for zero
    function automatic logic [ORD_W-1:0] msb_idx(input logic [CNT_W-1:0] n);
        logic [ORD_W-1:0] r;
        r = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (n[b]) r = ORD_W'(b);
        end
        msb_idx = r;
    endfunction

    // Smallest k with 2^k >= n, n nonzero
    function automatic logic [ORD_W-1:0] ceil_order(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] m;
        m = n - CNT_W'(1);
        if (n <= CNT_W'(1)) ceil_order = '0;
        else ceil_order = msb_idx(m) + ORD_W'(1);
    endfunction

endpackage

[rtl/core/bpa_mem.sv]
module bpa_mem
    import bpa_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_blk     o_rd
);

    t_blk mem [PAGES];

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rd <= mem[i_req.raddr];
        end
    end

endmodule

[rtl/core/bpa_ctrl.sv]
`include "buddy_page_allocator_defines.svh"
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [CNT_W-1:0]  i_page_count,
    input  logic [PAGE_W-1:0] i_page_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [PAGE_W-1:0] o_block_index,
    output logic [CNT_W-1:0]  o_avail_pages,
    input  logic              i_cfg_wr_en,
    input  logic [CNT_W-1:0]  i_cfg_wr_data,
    output t_mem_req          o_mem_req,
    input  t_blk              i_mem_rd
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SCAN, S_SPLIT, S_FCHK, S_MRD, S_MCHK, S_RESP
    } t_state;

    t_state            r_state, n_state;
    logic [PAGE_W-1:0] r_clr, n_clr;
    logic [ORD_W-1:0]  r_top, n_top;
    logic [CNT_W-1:0]  r_free_cnt, n_free_cnt;
    logic [ORD_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_addr, n_addr;
    logic              r_pend, n_pend;
    logic [PAGE_W-1:0] r_paddr, n_paddr;
    logic              r_found, n_found;
    logic [PAGE_W-1:0] r_best, n_best;
    logic [ORD_W-1:0]  r_j, n_j;
    logic [ORD_W-1:0]  r_o, n_o;
    logic [1:0]        r_st, n_st;
    logic [PAGE_W-1:0] r_idx, n_idx;
    logic              r_out_vld, n_out_vld;
    logic [1:0]        r_out_st, n_out_st;
    logic [PAGE_W-1:0] r_out_idx, n_out_idx;
    logic [CNT_W-1:0]  r_out_free, n_out_free;

    t_mem_req          req;
    logic [ORD_W-1:0]  cfg_top;
    logic [ORD_W-1:0]  rd_ord;
    logic [ORD_W-1:0]  cnt_k;
    logic [PAGE_W-1:0] bud;
    logic              hit;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_st;
    assign o_block_index = r_out_idx;
    assign o_avail_pages = r_out_free;
    assign o_mem_req     = req;

    assign cfg_top = (msb_idx(i_cfg_wr_data) > ORD_W'(ORDER_LIMIT)) ? ORD_W'(ORDER_LIMIT)
                                                                   : msb_idx(i_cfg_wr_data);
    assign rd_ord  = ORD_W'(i_mem_rd.order);
    assign cnt_k   = ceil_order(i_page_count);
    assign bud     = r_paddr ^ PAGE_W'(pow2(r_o));
    assign hit     = r_pend && i_mem_rd.free && (rd_ord >= r_k)
                     && (!r_found || (rd_ord < r_j));

    // Sequence one item through memory reads and writes
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_top      = r_top;
        n_free_cnt = r_free_cnt;
        n_k        = r_k;
        n_addr     = r_addr;
        n_pend     = r_pend;
        n_paddr    = r_paddr;
        n_found    = r_found;
        n_best     = r_best;
        n_j        = r_j;
        n_o        = r_o;
        n_st       = r_st;
        n_idx      = r_idx;
        n_out_vld  = r_out_vld;
        n_out_st   = r_out_st;
        n_out_idx  = r_out_idx;
        n_out_free = r_out_free;
        req        = '0;

        // Drop the delivered result
        if (r_out_vld && i_out_ready) n_out_vld = 1'b0;

        unique case (r_state)
            S_CLR: begin
                req.we    = 1'b1;
                req.waddr = r_clr;
                if (r_clr == '0) begin
                    req.wdata.free  = 1'b1;
                    req.wdata.order = r_top[3:0];
                end
                n_clr = r_clr + PAGE_W'(1);
                if (r_clr == {PAGE_W{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx = '0;
                    if (i_page_count == '0) begin
                        n_st    = ST_BADSIZE;
                        n_state = S_RESP;
                    end else if (i_command == CMD_ALLOC) begin
                        n_k     = cnt_k;
                        n_addr  = '0;
                        n_pend  = 1'b0;
                        n_found = 1'b0;
                        if (i_page_count > r_free_cnt || cnt_k > r_top) begin
                            n_st    = ST_NOSPACE;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        req.re    = 1'b1;
                        req.raddr = i_page_index;
                        n_paddr   = i_page_index;
                        n_k       = cnt_k;
                        n_state   = S_FCHK;
                    end
                end
            end
            S_SCAN: begin
                // Keep the smallest fitting order, lowest address first
                if (hit) begin
                    n_found = 1'b1;
                    n_best  = r_paddr;
                    n_j     = rd_ord;
                end
                if (hit && rd_ord == r_k) begin
                    n_state = S_SPLIT;
                end else if (r_addr < pow2(r_top)) begin
                    req.re    = 1'b1;
                    req.raddr = r_addr[PAGE_W-1:0];
                    n_pend    = 1'b1;
                    n_paddr   = r_addr[PAGE_W-1:0];
                    n_addr    = r_addr + pow2(r_k);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_found) begin
                            n_state = S_SPLIT;
                        end else begin
                            n_st    = ST_NOSPACE;
                            n_state = S_RESP;
                        end
                    end
                end
            end
            S_SPLIT: begin
                // Free the upper half at each level, then claim the block
                req.we = 1'b1;
                if (r_j > r_k) begin
                    req.waddr       = r_best | PAGE_W'(pow2(r_j - ORD_W'(1)));
                    req.wdata.free  = 1'b1;
                    req.wdata.order = 4'(r_j - ORD_W'(1));
                    n_j             = r_j - ORD_W'(1);
                end else begin
                    req.waddr       = r_best;
                    req.wdata.used  = 1'b1;
                    req.wdata.order = r_k[3:0];
                    n_free_cnt      = r_free_cnt - pow2(r_k);
                    n_st            = ST_OK;
                    n_idx           = r_best;
                    n_state         = S_RESP;
                end
            end
            S_FCHK: begin
                if (!i_mem_rd.used || rd_ord > r_top || rd_ord != r_k) begin
                    n_st    = ST_BADSIZE;
                    n_state = S_RESP;
                end else begin
                    req.we          = 1'b1;
                    req.waddr       = r_paddr;
                    req.wdata.order = i_mem_rd.order;
                    n_free_cnt      = r_free_cnt + pow2(rd_ord);
                    n_o             = rd_ord;
                    n_state         = S_MRD;
                end
            end
            S_MRD: begin
                if (r_o < r_top) begin
                    req.re    = 1'b1;
                    req.raddr = bud;
                    n_state   = S_MCHK;
                end else begin
                    req.we          = 1'b1;
                    req.waddr       = r_paddr;
                    req.wdata.free  = 1'b1;
                    req.wdata.order = r_o[3:0];
                    n_st            = ST_OK;
                    n_state         = S_RESP;
                end
            end
            S_MCHK: begin
                req.we = 1'b1;
                if (i_mem_rd.free && rd_ord == r_o) begin
                    // Absorb the buddy and climb one level
                    req.waddr       = bud;
                    req.wdata.order = i_mem_rd.order;
                    n_paddr         = r_paddr & ~PAGE_W'(pow2(r_o));
                    n_o             = r_o + ORD_W'(1);
                    n_state         = S_MRD;
                end else begin
                    req.waddr       = r_paddr;
                    req.wdata.free  = 1'b1;
                    req.wdata.order = r_o[3:0];
                    n_st            = ST_OK;
                    n_state         = S_RESP;
                end
            end
            S_RESP: begin
                // Hold until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld  = 1'b1;
                    n_out_st   = r_st;
                    n_out_idx  = r_idx;
                    n_out_free = r_free_cnt;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A pool write restarts the pool with a clearing pass
        if (i_cfg_wr_en) begin
            n_top      = cfg_top;
            n_free_cnt = pow2(cfg_top);
            n_clr      = '0;
            n_state    = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_top      <= ORD_W'(ORDER_LIMIT);
            r_free_cnt <= pow2(ORD_W'(ORDER_LIMIT));
            r_pend     <= 1'b0;
            r_found    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_top      <= n_top;
            r_free_cnt <= n_free_cnt;
            r_pend     <= n_pend;
            r_found    <= n_found;
            r_out_vld  <= n_out_vld;
        end
        r_k        <= n_k;
        r_addr     <= n_addr;
        r_paddr    <= n_paddr;
        r_best     <= n_best;
        r_j        <= n_j;
        r_o        <= n_o;
        r_st       <= n_st;
        r_idx      <= n_idx;
        r_out_st   <= n_out_st;
        r_out_idx  <= n_out_idx;
        r_out_free <= n_out_free;
    end

    `BPA_ASSERT_IMP(a_free_bound, r_state != S_CLR, r_free_cnt <= pow2(r_top))
    `BPA_ASSERT_IMP(a_split_range, r_state == S_SPLIT, r_j >= r_k && r_j <= r_top)
    `BPA_ASSERT_IMP(a_merge_below_top, r_state == S_MCHK, r_o < r_top)
    `BPA_ASSERT_NXT(a_one_item, i_in_valid && o_in_ready && !i_cfg_wr_en, !o_in_ready)

endmodule

[rtl/core/buddy_page_allocator.sv]
// Allocate: a scan over the candidate blocks of the requested size (up to
//   2^(top-k)), then one write per split level and one to claim the block.
// Free: a check of the block, then a buddy read and write per merge level;
//   a busy buddy ends the merge.
// One item at a time; the result register lets the next item in while a result waits.
// Reset and each pool write clear all 16384 page entries; no item is taken meanwhile.
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [CNT_W-1:0]  i_page_count,
    input  logic [PAGE_W-1:0] i_page_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [PAGE_W-1:0] o_block_index,
    output logic [CNT_W-1:0]  o_avail_pages,
    input  logic              i_cfg_wr_en,
    input  logic [CNT_W-1:0]  i_cfg_wr_data
);

    t_mem_req mem_req;
    t_blk     mem_rd;

    bpa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_page_count  (i_page_count),
        .i_page_index  (i_page_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_block_index (o_block_index),
        .o_avail_pages (o_avail_pages),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_mem_req     (mem_req),
        .i_mem_rd      (mem_rd)
    );

    bpa_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rd  (mem_rd)
    );

endmodule

[verif/buddy_page_allocator_tb.sv]
`timescale 1ns / 100ps
module buddy_page_allocator_tb
    import bpa_pkg::*;
();

    localparam int CYCLE_LIMIT = 6_000_000;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] block_index;
        logic [CNT_W-1:0]  avail_pages;
    } t_result;

    typedef struct {
        int unsigned idx;
        int unsigned ord;
    } t_held;

    typedef struct {
        logic        cmd;
        int unsigned cnt;
        int unsigned pidx;
        bit          known;
        t_result     res;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_command;
    logic [CNT_W-1:0]  i_page_count;
    logic [PAGE_W-1:0] i_page_index;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [1:0]        o_status;
    logic [PAGE_W-1:0] o_block_index;
    logic [CNT_W-1:0]  o_avail_pages;
    logic              i_cfg_wr_en;
    logic [CNT_W-1:0]  i_cfg_wr_data;

    // Shadow of the allocator
    bit          pg_free [PAGES];
    bit          pg_used [PAGES];
    int unsigned pg_ord  [PAGES];
    int unsigned pool_free;
    int unsigned pool_top;
    t_held       held_blocks[$];

    t_result     pending_results[$];
    bit          drv_known;
    t_result     drv_res;
    int unsigned n_accepted;
    int unsigned n_errors;
    int unsigned n_cycles;
    int unsigned burst_left;
    int unsigned alloc_lo;

    buddy_page_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_page_count  (i_page_count),
        .i_page_index  (i_page_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_block_index (o_block_index),
        .o_avail_pages (o_avail_pages),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Smallest order whose block holds n pages
    function automatic int unsigned order_for(int unsigned n);
        int unsigned k;
        k = 0;
        while ((1 << k) < n) k++;
        return k;
    endfunction

    // Rebuild the pool as one free block of the rounded size
    function automatic void pool_reset(int unsigned pages);
        int unsigned n;
        n = pages & 32'h7FFF;
        if (n == 0) n = 1;
        pool_top = 0;
        while (pool_top < ORDER_LIMIT && (2 << pool_top) <= n) pool_top++;
        for (int i = 0; i < PAGES; i++) begin
            pg_free[i] = 1'b0;
            pg_used[i] = 1'b0;
            pg_ord[i]  = 0;
        end
        pg_free[0] = 1'b1;
        pg_ord[0]  = pool_top;
        pool_free  = 1 << pool_top;
        held_blocks.delete();
    endfunction

    // Apply one request to the shadow and return the result it gives
    function automatic t_result apply_request(logic cmd, int unsigned cnt,
                                              int unsigned pidx);
        t_result     r;
        int unsigned k, o, b, bud, s;
        bit          found;
        int          hit[$];
        r = '0;
        if (cmd == CMD_ALLOC) begin
            r.status = ST_NOSPACE;
            if (cnt == 0) begin
                r.status = ST_BADSIZE;
            end else if (cnt <= pool_free && order_for(cnt) <= pool_top) begin
                k = order_for(cnt);
                found = 1'b0;
                for (int unsigned j = k; j <= pool_top && !found; j++) begin
                    for (int unsigned i = 0; i < (1 << pool_top) && !found;
                         i += (1 << j)) begin
                        if (pg_free[i] && pg_ord[i] == j) begin
                            found = 1'b1;
                            pg_free[i] = 1'b0;
                            s = j;
                            while (s > k) begin
                                s--;
                                pg_free[i + (1 << s)] = 1'b1;
                                pg_ord[i + (1 << s)]  = s;
                            end
                            pg_ord[i]  = k;
                            pg_used[i] = 1'b1;
                            pool_free -= 1 << k;
                            r.status = ST_OK;
                            r.block_index = PAGE_W'(i);
                            held_blocks.push_back('{idx: i, ord: k});
                        end
                    end
                end
            end
        end else begin
            r.status = ST_BADSIZE;
            b = pidx & (PAGES - 1);
            if (cnt != 0 && pg_used[b] && pg_ord[b] <= pool_top
                && order_for(cnt) == pg_ord[b]) begin
                r.status = ST_OK;
                o = pg_ord[b];
                pg_used[b] = 1'b0;
                pool_free += 1 << o;
                hit = held_blocks.find_first_index(h) with (h.idx == b);
                if (hit.size() > 0) held_blocks.delete(hit[0]);
                // merge upward while the buddy is free at the same order
                while (o < pool_top) begin
                    bud = b ^ (1 << o);
                    if (!(pg_free[bud] && pg_ord[bud] == o)) break;
                    pg_free[bud] = 1'b0;
                    if (bud < b) b = bud;
                    o++;
                end
                pg_free[b] = 1'b1;
                pg_ord[b]  = o;
            end
        end
        r.avail_pages = CNT_W'(pool_free);
        return r;
    endfunction

    // Predict on each accepted item, check each accepted result
    always @(posedge i_clk) begin
        t_result want, got, pred;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pred = apply_request(i_command, i_page_count, i_page_index);
                pending_results.push_back(drv_known ? drv_res : pred);
                n_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_status, o_block_index, o_avail_pages};
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result status %0d index %0d avail %0d",
                             $time, o_status, o_block_index, o_avail_pages);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        n_errors++;
                    end
                    if (got.block_index != want.block_index) begin
                        $display("%0t: block_index expected %0d got %0d",
                                 $time, want.block_index, got.block_index);
                        n_errors++;
                    end
                    if (got.avail_pages != want.avail_pages) begin
                        $display("%0t: avail_pages expected %0d got %0d",
                                 $time, want.avail_pages, got.avail_pages);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("buddy_page_allocator_tb failed");
            $finish;
        end
    end

    // Stall the result side on shifting patterns, with one long hold-off
    initial begin
        int unsigned mode, mode_left, hold;
        bit          hold_done;
        mode_left = 0;
        hold = 0;
        hold_done = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_accepted >= 300) begin
                hold_done = 1'b1;
                hold = 3000;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 9) != 0);
                    default: i_out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Offer one item and hold it until taken, then maybe leave a gap
    task automatic send(logic cmd, int unsigned cnt, int unsigned pidx,
                        bit known, t_result res);
        int unsigned gap;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_page_count <= CNT_W'(cnt);
        i_page_index <= PAGE_W'(pidx);
        drv_known    <= known;
        drv_res      <= res;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(0, 40);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Resize the pool once the block is idle
    task automatic set_pool(int unsigned pages);
        drain();
        repeat (40) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CNT_W'(pages);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pool_reset(pages);
    endtask

    // Mostly legal alloc/free traffic on live blocks, some noise
    task automatic random_items(int unsigned n);
        int unsigned r, e, cnt, pidx;
        t_held       h;
        for (int unsigned it = 0; it < n; it++) begin
            if ($urandom_range(0, 199) == 0) drain();
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send(CMD_ALLOC, $urandom_range(0, 32767), $urandom_range(0, 16383),
                     1'b0, '0);
            end else if (r < 50 || held_blocks.size() == 0) begin
                e = $urandom_range(alloc_lo < pool_top ? alloc_lo : pool_top, pool_top);
                cnt = (e == 0) ? 1 : $urandom_range((1 << (e - 1)) + 1, 1 << e);
                send(CMD_ALLOC, cnt, $urandom_range(0, 16383), 1'b0, '0);
            end else if (r < 88) begin
                h = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
                cnt = (h.ord == 0) ? 1 : $urandom_range((1 << (h.ord - 1)) + 1, 1 << h.ord);
                send(CMD_FREE, cnt, h.idx, 1'b0, '0);
            end else if (r < 94) begin
                // any size up to twice a live block's, mostly wrong
                h = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
                send(CMD_FREE, $urandom_range(0, 1 << (h.ord + 1)), h.idx, 1'b0, '0);
            end else begin
                pidx = $urandom_range(0, 16383);
                send(CMD_FREE, $urandom_range(0, 32767), pidx, 1'b0, '0);
            end
        end
    endtask

    t_row rows[] = '{
        '{CMD_ALLOC, 0,     0,     1, '{ST_BADSIZE, 0, 16384}},
        '{CMD_ALLOC, 32767, 16383, 1, '{ST_NOSPACE, 0, 16384}},
        '{CMD_ALLOC, 16384, 0,     1, '{ST_OK,      0, 0}},
        '{CMD_ALLOC, 1,     0,     1, '{ST_NOSPACE, 0, 0}},
        '{CMD_FREE,  16384, 0,     1, '{ST_OK,      0, 16384}},
        '{CMD_FREE,  16384, 0,     1, '{ST_BADSIZE, 0, 16384}},
        '{CMD_FREE,  0,     0,     1, '{ST_BADSIZE, 0, 16384}},
        '{CMD_ALLOC, 3,     0,     0, '0},
        '{CMD_ALLOC, 1,     0,     0, '0},
        '{CMD_ALLOC, 5000,  0,     0, '0},
        '{CMD_FREE,  3,     16383, 0, '0},
        '{CMD_FREE,  2,     4,     0, '0},
        '{CMD_FREE,  1,     4,     0, '0},
        '{CMD_FREE,  4,     0,     0, '0},
        '{CMD_FREE,  4,     0,     0, '0},
        '{CMD_ALLOC, 8192,  0,     0, '0},
        '{CMD_FREE,  8192,  0,     0, '0},
        '{CMD_ALLOC, 1,     0,     0, '0},
        '{CMD_ALLOC, 8000,  0,     0, '0},
        '{CMD_ALLOC, 4096,  0,     0, '0},
        '{CMD_ALLOC, 8192,  0,     0, '0}
    };

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = CMD_ALLOC;
        i_page_count  = '0;
        i_page_index  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        drv_known     = 1'b0;
        drv_res       = '0;
        n_accepted    = 0;
        n_errors      = 0;
        n_cycles      = 0;
        burst_left    = 0;
        alloc_lo      = 0;
        pool_reset(16384);
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table against the reset pool
        foreach (rows[i]) send(rows[i].cmd, rows[i].cnt, rows[i].pidx,
                               rows[i].known, rows[i].res);

        set_pool(0);
        random_items(30);
        // Large pool: keep sizes large so scans stay short
        set_pool(32767);
        alloc_lo = 9;
        random_items(80);
        alloc_lo = 0;
        set_pool(1);
        random_items(10);
        set_pool(100);
        random_items(400);
        set_pool(5);
        random_items(200);
        set_pool(256);
        random_items(400);
        set_pool(1000);
        random_items(400);

        drain();
        repeat (60) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("buddy_page_allocator_tb passed");
        end else begin
            $display("buddy_page_allocator_tb failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_mem.sv
rtl/core/bpa_ctrl.sv
rtl/core/buddy_page_allocator.sv
verif/buddy_page_allocator_tb.sv
